>>> design/rpp_pkg.sv
// Shared constants and types for the reply packet parser.
`default_nettype none

package rpp_pkg;

    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned BATT_W   = 16;
    localparam int unsigned KA_W     = 32;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [BATT_W-1:0]   t_batt;
    typedef logic [KA_W-1:0]     t_ka;

    localparam t_byte CMD_BATTERY   = 8'h0b;
    localparam t_byte CMD_KEEPALIVE = 8'h0d;
    localparam t_byte STATUS_OK     = 8'h00;

    localparam t_pos CMD_OFFSET    = 4'd3;
    localparam t_pos STATUS_OFFSET = 4'd4;
    localparam t_pos VALUE_OFFSET  = 4'd5;
    localparam t_pos BATTERY_LAST  = 4'd6;  // 7-byte packet
    localparam t_pos KEEPALIVE_LAST = 4'd8; // 9-byte packet

endpackage

`default_nettype wire

>>> design/rpp_if.sv
// Channel interfaces of the reply packet parser: byte input, result output, config write.
`default_nettype none

interface rpp_in_if;
    logic              valid;
    logic              ready;
    rpp_pkg::t_byte    data_byte;
    rpp_pkg::t_handle  link_handle;
    logic              last_byte;

    modport source (output valid, output data_byte, output link_handle, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input link_handle, input last_byte,
                    output ready);
endinterface

interface rpp_out_if;
    logic            valid;
    logic            ready;
    logic            buffer_ok;
    rpp_pkg::t_batt  battery_mv;
    rpp_pkg::t_ka    keepalive_ms;

    modport source (output valid, output buffer_ok, output battery_mv, output keepalive_ms,
                    input ready);
    modport sink   (input valid, input buffer_ok, input battery_mv, input keepalive_ms,
                    output ready);
endinterface

interface rpp_cfg_if;
    logic              valid;
    logic              ready;
    rpp_pkg::t_handle  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/reply_packet_parser.sv
// Top level of the reply packet parser: byte register, decode logic, result register.
// Takes one reply byte per cycle with its link handle and an end-of-buffer mark. Buffers whose
// handle differs from the configured peer handle halt and report failure. Packets run back to
// back: command 0x0b is a 7-byte battery reply (16-bit little-endian millivolts at offset 5),
// command 0x0d a 9-byte keep-alive reply (32-bit milliseconds at offset 5); a value is stored
// only when its packet completes with a zero status byte. One result leaves per buffer, on its
// last byte: buffer_ok plus the latest stored battery and keep-alive values. A byte passes an
// input register, then is decoded into the parser state and the result register, and a new
// byte is taken every cycle but for one stall: a held result blocking the next last byte. The
// peer handle register is written through the config channel, which is always ready; the user
// must write it only while the block is idle, which the block itself does not enforce.
`default_nettype none

module reply_packet_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rpp_in_if.sink      i_rx,
    rpp_out_if.source   o_tx,
    rpp_cfg_if.sink     i_cfg
);

    // Config
    rpp_pkg::t_handle r_peer;

    // Input register
    logic              r_in_valid;
    rpp_pkg::t_byte    r_in_byte;
    rpp_pkg::t_handle  r_in_handle;
    logic              r_in_last;

    // Parser state
    rpp_pkg::t_pos  r_pos,      n_pos;
    logic           r_ka,       n_ka;
    logic           r_status,   n_status;
    rpp_pkg::t_ka   r_gather,   n_gather;
    logic           r_halted,   n_halted;
    rpp_pkg::t_batt r_battery,  n_battery;
    rpp_pkg::t_ka   r_keepalive, n_keepalive;

    // Result register
    logic            r_out_valid;
    logic            r_out_ok;
    rpp_pkg::t_batt  r_out_batt;
    rpp_pkg::t_ka    r_out_ka;
    logic            n_out_ok;

    logic            advance;
    logic            in_take;
    rpp_pkg::t_ka    gather_base;
    rpp_pkg::t_pos   last_pos;
    logic            cmd_bad;

    // A last byte needs a free result slot; other bytes always move on.
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || o_tx.ready);
    assign i_rx.ready = !r_in_valid || advance;
    assign in_take = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    assign o_tx.valid        = r_out_valid;
    assign o_tx.buffer_ok    = r_out_ok;
    assign o_tx.battery_mv   = r_out_batt;
    assign o_tx.keepalive_ms = r_out_ka;

    always_comb begin
        n_pos       = r_pos;
        n_ka        = r_ka;
        n_status    = r_status;
        n_gather    = r_gather;
        n_halted    = r_halted;
        n_battery   = r_battery;
        n_keepalive = r_keepalive;
        cmd_bad     = 1'b0;
        gather_base = (r_pos == '0) ? '0 : r_gather;
        last_pos    = rpp_pkg::BATTERY_LAST;
        n_out_ok    = 1'b0;

        if (!r_halted) begin
            if (r_in_handle != r_peer) begin
                n_halted = 1'b1;
            end else begin
                n_gather = gather_base;
                case (r_pos)
                    rpp_pkg::CMD_OFFSET: begin
                        if (r_in_byte == rpp_pkg::CMD_BATTERY) begin
                            n_ka = 1'b0;
                        end else if (r_in_byte == rpp_pkg::CMD_KEEPALIVE) begin
                            n_ka = 1'b1;
                        end else begin
                            cmd_bad = 1'b1;
                        end
                    end
                    rpp_pkg::STATUS_OFFSET: begin
                        n_status = (r_in_byte == rpp_pkg::STATUS_OK);
                    end
                    4'd5: n_gather[7:0]   = gather_base[7:0]   | r_in_byte;
                    4'd6: n_gather[15:8]  = gather_base[15:8]  | r_in_byte;
                    4'd7: n_gather[23:16] = gather_base[23:16] | r_in_byte;
                    4'd8: n_gather[31:24] = gather_base[31:24] | r_in_byte;
                    default: ;
                endcase

                if (cmd_bad) begin
                    n_halted = 1'b1;
                end else begin
                    last_pos = n_ka ? rpp_pkg::KEEPALIVE_LAST : rpp_pkg::BATTERY_LAST;
                    if (r_pos >= rpp_pkg::CMD_OFFSET && r_pos == last_pos) begin
                        if (n_status) begin
                            if (n_ka) begin
                                n_keepalive = n_gather;
                            end else begin
                                n_battery = n_gather[rpp_pkg::BATT_W-1:0];
                            end
                        end
                        n_pos = '0;
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
        end

        if (r_in_last) begin
            n_out_ok = !n_halted && (n_pos == '0);
            n_pos    = '0;
            n_ka     = 1'b0;
            n_status = 1'b0;
            n_gather = '0;
            n_halted = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer      <= '0;
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_ka        <= 1'b0;
            r_status    <= 1'b0;
            r_gather    <= '0;
            r_halted    <= 1'b0;
            r_battery   <= '0;
            r_keepalive <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_peer <= i_cfg.data;
            end

            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end

            if (advance) begin
                r_pos       <= n_pos;
                r_ka        <= n_ka;
                r_status    <= n_status;
                r_gather    <= n_gather;
                r_halted    <= n_halted;
                r_battery   <= n_battery;
                r_keepalive <= n_keepalive;
            end

            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_tx.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte   <= i_rx.data_byte;
            r_in_handle <= i_rx.link_handle;
            r_in_last   <= i_rx.last_byte;
        end
        if (advance && r_in_last) begin
            r_out_ok   <= n_out_ok;
            r_out_batt <= n_battery;
            r_out_ka   <= n_keepalive;
        end
    end

    // Packet offset never runs past the end of the longest packet.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= rpp_pkg::KEEPALIVE_LAST)
        else $error("packet offset out of range");

    // End of buffer leaves the per-buffer state clear.
    a_buf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_pos == '0 && !r_halted && r_gather == '0)
        else $error("buffer state not cleared after last byte");

    // Every processed last byte produces a result.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_out_valid)
        else $error("last byte produced no result");

    // Stored values change only when a byte is processed.
    a_store_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_battery) && $stable(r_keepalive))
        else $error("store changed without a byte");

    // A halted buffer never stores a value.
    a_halt_nostore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_halted |=> $stable(r_battery) && $stable(r_keepalive))
        else $error("store changed in halted buffer");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the reply packet parser: directed and random reply buffers.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam t_byte CMD_UNKNOWN = 8'h0c;

    typedef struct {
        t_byte   data;
        t_handle handle;
        logic    last;
    } rx_byte_t;

    typedef struct {
        logic  ok;
        t_batt batt;
        t_ka   ka;
    } reply_t;

    logic clk;
    logic rst_n;

    rpp_in_if  rx();
    rpp_out_if tx();
    rpp_cfg_if cfg();

    reply_packet_parser u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx),
        .o_tx    (tx),
        .i_cfg   (cfg)
    );

    // parser image, kept in step with accepted transactions
    t_handle peer_handle    = '0;
    t_pos    parse_pos      = '0;
    logic    in_keepalive   = 1'b0;
    logic    status_zero    = 1'b0;
    t_ka     value_acc      = '0;
    logic    halted         = 1'b0;
    t_batt   battery_mv_q   = '0;
    t_ka     keepalive_ms_q = '0;

    rx_byte_t byte_backlog[$];
    reply_t   pending_replies[$];
    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int rx_gap_pct    = 0;
    int tx_stall_pct  = 0;
    int rx_gap_left   = 0;
    int tx_stall_left = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic parse_reply_byte(input t_byte b, input t_handle h, input logic last);
        t_pos   end_pos;
        reply_t r;
        if (!halted) begin
            if (h != peer_handle) begin
                halted = 1'b1;
            end else if (parse_pos == CMD_OFFSET && b != CMD_BATTERY && b != CMD_KEEPALIVE) begin
                halted = 1'b1;
            end else begin
                if (parse_pos == '0) begin
                    value_acc = '0;
                end
                if (parse_pos == CMD_OFFSET) begin
                    in_keepalive = (b == CMD_KEEPALIVE);
                end else if (parse_pos == STATUS_OFFSET) begin
                    status_zero = (b == STATUS_OK);
                end else if (parse_pos >= VALUE_OFFSET && parse_pos <= KEEPALIVE_LAST) begin
                    value_acc |= t_ka'(b) << (8 * (parse_pos - VALUE_OFFSET));
                end
                end_pos = in_keepalive ? KEEPALIVE_LAST : BATTERY_LAST;
                if (parse_pos >= CMD_OFFSET && parse_pos == end_pos) begin
                    if (status_zero) begin
                        if (in_keepalive) begin
                            keepalive_ms_q = value_acc;
                        end else begin
                            battery_mv_q = value_acc[BATT_W-1:0];
                        end
                    end
                    parse_pos = '0;
                end else begin
                    parse_pos = parse_pos + 1'b1;
                end
            end
        end
        if (last) begin
            r.ok   = !halted && parse_pos == '0;
            r.batt = battery_mv_q;
            r.ka   = keepalive_ms_q;
            pending_replies.push_back(r);
            parse_pos    = '0;
            in_keepalive = 1'b0;
            status_zero  = 1'b0;
            value_acc    = '0;
            halted       = 1'b0;
        end
    endtask

    function automatic t_ka random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return t_ka'($urandom);
    endfunction

    function automatic t_byte random_status();
        if ($urandom_range(0, 3) != 0) begin
            return STATUS_OK;
        end
        return t_byte'($urandom_range(1, 255));
    endfunction

    // appends the first keep bytes of one packet
    task automatic add_packet(ref t_byte bytes[$], input t_byte cmd, input t_byte status,
                              input t_ka value, input int keep);
        int len;
        len = (cmd == CMD_KEEPALIVE) ? 9 : 7;
        for (int i = 0; i < len && i < keep; i++) begin
            if (i < CMD_OFFSET) begin
                bytes.push_back(t_byte'($urandom));
            end else if (i == CMD_OFFSET) begin
                bytes.push_back(cmd);
            end else if (i == STATUS_OFFSET) begin
                bytes.push_back(status);
            end else begin
                bytes.push_back(value[8*(i-VALUE_OFFSET) +: 8]);
            end
        end
    endtask

    // from index bad_at on, bytes carry another link's handle
    task automatic queue_buffer(input t_byte bytes[$], input t_handle h, input int bad_at,
                                input t_handle bad_h);
        rx_byte_t item;
        foreach (bytes[i]) begin
            item.data   = bytes[i];
            item.handle = (bad_at >= 0 && i >= bad_at) ? bad_h : h;
            item.last   = (i == bytes.size() - 1);
            byte_backlog.push_back(item);
            bytes_queued++;
        end
    endtask

    task automatic add_random_buffer();
        t_byte   bytes[$];
        t_handle h;
        t_handle bad_h;
        t_byte   cmd;
        int      kind;
        int      bad_at;
        kind   = $urandom_range(0, 99);
        h      = peer_handle;
        bad_at = -1;
        bad_h  = t_handle'($urandom);
        if (bad_h == peer_handle) begin
            bad_h = ~peer_handle;
        end
        if (kind < 92) begin
            repeat ($urandom_range((kind >= 60 && kind < 80) ? 0 : 1, 3)) begin
                cmd = $urandom_range(0, 1) ? CMD_KEEPALIVE : CMD_BATTERY;
                add_packet(bytes, cmd, random_status(), random_value(), 9);
            end
        end
        if (kind >= 60 && kind < 72) begin
            // buffer ends partway through a packet
            cmd = $urandom_range(0, 1) ? CMD_KEEPALIVE : CMD_BATTERY;
            add_packet(bytes, cmd, random_status(), random_value(),
                       $urandom_range(1, (cmd == CMD_KEEPALIVE) ? 8 : 6));
        end else if (kind >= 72 && kind < 80) begin
            do begin
                cmd = t_byte'($urandom);
            end while (cmd == CMD_BATTERY || cmd == CMD_KEEPALIVE);
            add_packet(bytes, cmd, random_status(), random_value(), 4);
            repeat ($urandom_range(0, 6)) bytes.push_back(t_byte'($urandom));
        end else if (kind >= 80 && kind < 92) begin
            if ($urandom_range(0, 3) == 0) begin
                h = bad_h;
            end else begin
                bad_at = $urandom_range(0, bytes.size() - 1);
            end
        end else if (kind >= 92) begin
            repeat ($urandom_range(1, 12)) bytes.push_back(t_byte'($urandom));
            if ($urandom_range(0, 1)) begin
                h = bad_h;
            end
        end
        queue_buffer(bytes, h, bad_at, bad_h);
    endtask

    task automatic write_peer(input t_handle value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        peer_handle = value;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (bytes_taken != bytes_queued || pending_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input t_handle peer, input int min_bytes, input int gap_pct,
                             input int stall_pct);
        int start;
        write_peer(peer);
        rx_gap_pct   = gap_pct;
        tx_stall_pct = stall_pct;
        start = bytes_queued;
        while (bytes_queued - start < min_bytes) begin
            add_random_buffer();
        end
        wait_drained();
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // byte driver: a new transaction only once the current one is taken
    always @(posedge clk) begin
        rx_byte_t item;
        if (!rst_n) begin
            rx.valid <= 1'b0;
        end else if (!rx.valid || rx.ready) begin
            if (rx_gap_left > 0) begin
                rx_gap_left--;
                rx.valid <= 1'b0;
            end else if (byte_backlog.size() != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
                rx_gap_left = $urandom_range(0, 15);
                rx.valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
                item = byte_backlog.pop_front();
                rx.valid       <= 1'b1;
                rx.data_byte   <= item.data;
                rx.link_handle <= item.handle;
                rx.last_byte   <= item.last;
            end else begin
                rx.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rx.valid && rx.ready) begin
            parse_reply_byte(rx.data_byte, rx.link_handle, rx.last_byte);
            bytes_taken++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            tx.ready <= 1'b0;
        end else if (tx_stall_left > 0) begin
            tx_stall_left--;
            tx.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < tx_stall_pct) begin
            tx_stall_left = $urandom_range(0, 15);
            tx.ready <= 1'b0;
        end else begin
            tx.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        reply_t want;
        if (rst_n && tx.valid && tx.ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("result with no buffer closed: ok=%0b batt=%h ka=%h",
                                          tx.buffer_ok, tx.battery_mv, tx.keepalive_ms));
            end else begin
                want = pending_replies.pop_front();
                if (tx.buffer_ok !== want.ok) begin
                    report_mismatch($sformatf("buffer_ok got %b want %b",
                                              tx.buffer_ok, want.ok));
                end
                if (tx.battery_mv !== want.batt) begin
                    report_mismatch($sformatf("battery_mv got %h want %h",
                                              tx.battery_mv, want.batt));
                end
                if (tx.keepalive_ms !== want.ka) begin
                    report_mismatch($sformatf("keepalive_ms got %h want %h",
                                              tx.keepalive_ms, want.ka));
                end
            end
        end
    end

    initial begin
        t_byte pkt_bytes[$];
        rx.valid       = 1'b0;
        rx.data_byte   = '0;
        rx.link_handle = '0;
        rx.last_byte   = 1'b0;
        tx.ready       = 1'b0;
        cfg.valid      = 1'b0;
        cfg.data       = '0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: both packet kinds at full scale, unknown command, short buffer,
        // byte from another link
        write_peer('1);
        add_packet(pkt_bytes, CMD_BATTERY, STATUS_OK, 32'h0000_ffff, 9);
        add_packet(pkt_bytes, CMD_KEEPALIVE, STATUS_OK, '1, 9);
        queue_buffer(pkt_bytes, peer_handle, -1, '0);
        pkt_bytes.delete();
        add_packet(pkt_bytes, CMD_UNKNOWN, STATUS_OK, '0, 4);
        queue_buffer(pkt_bytes, peer_handle, -1, '0);
        pkt_bytes.delete();
        pkt_bytes.push_back(8'h00);
        queue_buffer(pkt_bytes, peer_handle, -1, '0);
        queue_buffer(pkt_bytes, '0, -1, '0);
        wait_drained();

        run_phase('0, 300, 20, 5);
        run_phase(t_handle'($urandom), 300, 0, 0);
        run_phase(t_handle'($urandom), 300, 35, 15);
        run_phase('1, 300, 10, 3);
        // tail runs at full rate
        run_phase(t_handle'($urandom), 300, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
